>>> hw/rtl/stack_bytecode_executor_macros.svh
// ----------------------------------------------------------------------------
// Stack bytecode executor assertion macros
// Shared concurrent assertion forms used by the executor RTL.
// ----------------------------------------------------------------------------
`ifndef STACK_BYTECODE_EXECUTOR_MACROS_SVH
`define STACK_BYTECODE_EXECUTOR_MACROS_SVH

// condition holds on every clock edge out of reset
`define SBE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("sbe: invariant violated");

// consequent holds in the same cycle as the antecedent
`define SBE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbe: implication violated");

// consequent holds in the cycle after the antecedent
`define SBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbe: next-cycle implication violated");

`endif

>>> hw/rtl/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg
// Types and constants shared by the stack bytecode executor modules.
// ----------------------------------------------------------------------------
package sbe_pkg;

   localparam int unsigned STACK_DEPTH_DEF   = 64;
   localparam int unsigned LOCAL_COUNT_DEF   = 3;
   localparam int unsigned PROGRAM_WORDS_DEF = 256;

   localparam int WORD_W  = 32;
   localparam int OP_W    = 4;
   localparam int MOD_W   = 30;
   localparam int FAULT_W = 2;

   localparam logic [WORD_W-1:0] MOD_PRIME   = 32'd1000000007;
   localparam logic [WORD_W-1:0] COUNT_RESET = 32'd800000;
   // local slot that holds the loop bound
   localparam int unsigned COUNT_SLOT = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 4'd0,
      OP_LOAD  = 4'd1,
      OP_STORE = 4'd2,
      OP_ADD   = 4'd3,
      OP_MUL   = 4'd4,
      OP_SUB   = 4'd5,
      OP_LT    = 4'd6,
      OP_JZ    = 4'd7,
      OP_JMP   = 4'd8,
      OP_HALT  = 4'd9
   } opcode_type;

   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_UNDERFLOW = 2'd1,
      FAULT_OVERFLOW  = 2'd2,
      FAULT_BAD_SLOT  = 2'd3
   } fault_type;

endpackage

>>> hw/rtl/sbe_stack_ram.sv
// ----------------------------------------------------------------------------
// sbe_stack_ram
// Operand stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbe_stack_ram #(
   parameter int unsigned DEPTH = sbe_pkg::STACK_DEPTH_DEF,
   parameter int unsigned WIDTH = sbe_pkg::WORD_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sbe_mod_reduce.sv
// ----------------------------------------------------------------------------
// sbe_mod_reduce
// Reduces a 32-bit word modulo the prime 1000000007.
// ----------------------------------------------------------------------------
module sbe_mod_reduce (
   input  logic [sbe_pkg::WORD_W-1:0] value,
   output logic [sbe_pkg::MOD_W-1:0]  residue
);

   logic [sbe_pkg::WORD_W:0] value_ext;
   logic [sbe_pkg::WORD_W:0] rem;
   logic [sbe_pkg::WORD_W:0] bound;

   // a 32-bit word holds at most four multiples of the prime; the compares are
   // independent and the largest multiple that fits wins
   always_comb begin
      value_ext = {1'b0, value};
      rem       = value_ext;
      bound     = '0;
      for (int k = 1; k <= 4; k++) begin
         bound = (sbe_pkg::WORD_W + 1)'(sbe_pkg::MOD_PRIME) * (sbe_pkg::WORD_W + 1)'(k);
         if (value_ext >= bound) begin
            rem = value_ext - bound;
         end
      end
   end

   assign residue = rem[sbe_pkg::MOD_W-1:0];

endmodule

>>> hw/rtl/stack_bytecode_executor.sv
// ----------------------------------------------------------------------------
// stack_bytecode_executor
// Executes one decoded stack-machine instruction per request word and returns
// the next fetch address, the top of stack, the halt status and the fault code.
// ----------------------------------------------------------------------------
// Each accepted request word waits in the execute register until the response
// register can take its result; the result is then registered there. With the
// response side taking words, one instruction completes every cycle: the top
// of stack lives in a register and the entry below it is read ahead from the
// stack RAM, addressed by the stack pointer that the executing instruction
// leaves behind, so the RAM read port never stalls the pipe. A stalled response
// holds one word in the execute register and one in the response register
// before request ready drops. Writing the CSR loads local slot two directly.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "stack_bytecode_executor_macros.svh"

module stack_bytecode_executor #(
   parameter int unsigned STACK_DEPTH   = sbe_pkg::STACK_DEPTH_DEF,
   parameter int unsigned LOCAL_COUNT   = sbe_pkg::LOCAL_COUNT_DEF,
   parameter int unsigned PROGRAM_WORDS = sbe_pkg::PROGRAM_WORDS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [sbe_pkg::WORD_W-1:0]         csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sbe_pkg::OP_W-1:0]           req_op,
   input  logic [sbe_pkg::WORD_W-1:0]         req_operand,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [$clog2(PROGRAM_WORDS)-1:0]   rsp_next_pc,
   output logic [sbe_pkg::WORD_W-1:0]         rsp_top_value,
   output logic [sbe_pkg::MOD_W-1:0]          rsp_result_mod,
   output logic                               rsp_halted,
   output logic [sbe_pkg::FAULT_W-1:0]        rsp_fault
);

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int SLOT_W = $clog2(LOCAL_COUNT);
   localparam int PC_W   = $clog2(PROGRAM_WORDS);
   localparam int W      = sbe_pkg::WORD_W;

   localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
   localparam logic [PC_W:0]   PW_EXT  = (PC_W + 1)'(PROGRAM_WORDS);
   localparam logic [W-1:0]    PW_WORD = W'(PROGRAM_WORDS);
   // floor(2^32 / PROGRAM_WORDS): quotient estimate is low by at most one
   localparam logic [2*W-1:0]  RECIP_FULL = (64'd1 << W) / 64'(PROGRAM_WORDS);
   localparam logic [W-1:0]    RECIP      = RECIP_FULL[W-1:0];

   // execute stage
   logic                 ex_valid_ff;
   logic                 ex_valid_in;
   logic [sbe_pkg::OP_W-1:0] ex_op_ff;
   logic [W-1:0]         ex_arg_ff;
   logic [W-1:0]         ex_quot_ff;
   logic [2*W-1:0]       quot_prod;
   logic                 ex_fire;
   logic                 req_fire;

   // architectural state
   logic [SP_W-1:0]      sp_ff, sp_in;
   logic [W-1:0]         tos_ff, tos_in;
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic                 halted_ff, halted_in;
   sbe_pkg::fault_type   fault_ff, fault_in;
   logic [W-1:0]         slot_ff [LOCAL_COUNT];
   logic                 slot_we;

   // stack RAM
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [W-1:0]         ram_wdata;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [W-1:0]         nos;

   // datapath
   logic [SLOT_W-1:0]    slot_idx;
   logic                 slot_bad;
   logic [W-1:0]         slot_val;
   logic [W-1:0]         push_val;
   logic [2*W-1:0]       mul_full;
   logic [W-1:0]         alu_res;
   logic [PC_W:0]        pc_sum1, pc_sum2;
   logic [PC_W-1:0]      pc_inc1, pc_inc2;
   logic [W-1:0]         jmp_rem, jmp_word;
   logic [PC_W-1:0]      jmp_tgt;
   logic [W-1:0]         cur_top;
   logic [sbe_pkg::MOD_W-1:0] cur_mod;

   // response register
   logic                 rsp_valid_ff;
   logic [PC_W-1:0]      rsp_pc_ff;
   logic [W-1:0]         rsp_top_ff;
   logic [sbe_pkg::MOD_W-1:0] rsp_mod_ff;
   logic                 rsp_halted_ff;
   sbe_pkg::fault_type   rsp_fault_ff;

   assign ex_fire   = ex_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !ex_valid_ff || ex_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      ex_valid_in = ex_valid_ff;
      if (req_fire) begin
         ex_valid_in = 1'b1;
      end else if (ex_fire) begin
         ex_valid_in = 1'b0;
      end
   end

   // quotient estimate for the jump target, finished in the execute stage
   assign quot_prod = 64'(req_operand) * 64'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff <= ex_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ex_op_ff   <= req_op;
         ex_arg_ff  <= req_operand;
         ex_quot_ff <= quot_prod[2*W-1:W];
      end
   end

   // ------------------------------------------------------------------
   // operand decode and arithmetic
   // ------------------------------------------------------------------
   assign slot_idx = ex_arg_ff[SLOT_W-1:0];
   assign slot_bad = ex_arg_ff >= W'(LOCAL_COUNT);
   assign slot_val = slot_bad ? '0 : slot_ff[slot_idx];
   assign push_val = (ex_op_ff == sbe_pkg::OP_LOAD) ? slot_val : ex_arg_ff;
   assign mul_full = nos * tos_ff;

   always_comb begin
      case (ex_op_ff)
         sbe_pkg::OP_ADD: alu_res = nos + tos_ff;
         sbe_pkg::OP_MUL: alu_res = mul_full[W-1:0];
         sbe_pkg::OP_SUB: alu_res = nos - tos_ff;
         default:         alu_res = {{(W-1){1'b0}}, nos < tos_ff};
      endcase
   end

   always_comb begin
      pc_sum1  = {1'b0, pc_ff} + (PC_W + 1)'(1);
      pc_sum2  = {1'b0, pc_ff} + (PC_W + 1)'(2);
      pc_inc1  = (pc_sum1 >= PW_EXT) ? PC_W'(pc_sum1 - PW_EXT) : pc_sum1[PC_W-1:0];
      pc_inc2  = (pc_sum2 >= PW_EXT) ? PC_W'(pc_sum2 - PW_EXT) : pc_sum2[PC_W-1:0];
      // remainder lands below twice the program size; fold once
      jmp_rem  = ex_arg_ff - ex_quot_ff * PW_WORD;
      jmp_word = (jmp_rem >= PW_WORD) ? jmp_rem - PW_WORD : jmp_rem;
      jmp_tgt  = jmp_word[PC_W-1:0];
   end

   // ------------------------------------------------------------------
   // execute: next architectural state
   // ------------------------------------------------------------------
   always_comb begin
      sp_in     = sp_ff;
      tos_in    = tos_ff;
      pc_in     = pc_ff;
      halted_in = halted_ff;
      fault_in  = fault_ff;
      slot_we   = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(sp_ff);
      ram_wdata = push_val;
      if (ex_fire && !halted_ff) begin
         unique case (ex_op_ff) inside
            sbe_pkg::OP_PUSH, sbe_pkg::OP_LOAD: begin
               if ((ex_op_ff == sbe_pkg::OP_LOAD) && slot_bad) begin
                  fault_in  = sbe_pkg::FAULT_BAD_SLOT;
                  halted_in = 1'b1;
               end else if (sp_ff == SP_FULL) begin
                  fault_in  = sbe_pkg::FAULT_OVERFLOW;
                  halted_in = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = ADDR_W'(sp_ff);
                  ram_wdata = push_val;
                  sp_in     = sp_ff + SP_W'(1);
                  tos_in    = push_val;
                  pc_in     = pc_inc2;
               end
            end
            sbe_pkg::OP_STORE: begin
               if (slot_bad) begin
                  fault_in  = sbe_pkg::FAULT_BAD_SLOT;
                  halted_in = 1'b1;
               end else if (sp_ff == '0) begin
                  fault_in  = sbe_pkg::FAULT_UNDERFLOW;
                  halted_in = 1'b1;
               end else begin
                  slot_we = 1'b1;
                  sp_in   = sp_ff - SP_W'(1);
                  tos_in  = nos;
                  pc_in   = pc_inc2;
               end
            end
            sbe_pkg::OP_ADD, sbe_pkg::OP_MUL, sbe_pkg::OP_SUB, sbe_pkg::OP_LT: begin
               if (sp_ff < SP_W'(2)) begin
                  fault_in  = sbe_pkg::FAULT_UNDERFLOW;
                  halted_in = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = ADDR_W'(sp_ff - SP_W'(2));
                  ram_wdata = alu_res;
                  sp_in     = sp_ff - SP_W'(1);
                  tos_in    = alu_res;
                  pc_in     = pc_inc1;
               end
            end
            sbe_pkg::OP_JZ: begin
               if (sp_ff == '0) begin
                  fault_in  = sbe_pkg::FAULT_UNDERFLOW;
                  halted_in = 1'b1;
               end else begin
                  sp_in  = sp_ff - SP_W'(1);
                  tos_in = nos;
                  pc_in  = (tos_ff == '0) ? jmp_tgt : pc_inc2;
               end
            end
            sbe_pkg::OP_JMP: begin
               pc_in = jmp_tgt;
            end
            sbe_pkg::OP_HALT: begin
               if (sp_ff == '0) begin
                  fault_in = sbe_pkg::FAULT_UNDERFLOW;
               end
               halted_in = 1'b1;
            end
            default: begin
               pc_in = pc_inc1;
            end
         endcase
      end
   end

   // prefetch the entry below the top for whatever stack pointer comes next;
   // the write of this cycle always lands one entry higher
   assign ram_raddr = ADDR_W'(sp_in - SP_W'(2));

   sbe_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (nos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff     <= '0;
         pc_ff     <= '0;
         halted_ff <= 1'b0;
         fault_ff  <= sbe_pkg::FAULT_NONE;
         for (int i = 0; i < LOCAL_COUNT; i++) begin
            slot_ff[i] <= (i == sbe_pkg::COUNT_SLOT) ? sbe_pkg::COUNT_RESET : '0;
         end
      end else begin
         sp_ff     <= sp_in;
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
         fault_ff  <= fault_in;
         if (slot_we) begin
            slot_ff[slot_idx] <= tos_ff;
         end
         // CSR write wins over a store to the same slot
         if (csr_wr_en) begin
            slot_ff[sbe_pkg::COUNT_SLOT] <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
   end

   // ------------------------------------------------------------------
   // response
   // ------------------------------------------------------------------
   // the stack never moves on a halting step, so the current top is the one reported
   assign cur_top = (sp_ff == '0) ? '0 : tos_ff;

   sbe_mod_reduce u_mod_reduce (
      .value   (cur_top),
      .residue (cur_mod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ex_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_fire) begin
         rsp_pc_ff     <= pc_in;
         rsp_top_ff    <= (sp_in == '0) ? '0 : tos_in;
         rsp_mod_ff    <= halted_in ? cur_mod : '0;
         rsp_halted_ff <= halted_in;
         rsp_fault_ff  <= fault_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_pc    = rsp_pc_ff;
   assign rsp_top_value  = rsp_top_ff;
   assign rsp_result_mod = rsp_mod_ff;
   assign rsp_halted     = rsp_halted_ff;
   assign rsp_fault      = rsp_fault_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `SBE_ASSERT_ALWAYS(a_sp_in_range, clock, reset, sp_ff <= SP_FULL)
   `SBE_ASSERT_IMPLIES(a_fault_halts, clock, reset, fault_ff != sbe_pkg::FAULT_NONE, halted_ff)
   `SBE_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff && $stable(sp_ff))
   `SBE_ASSERT_IMPLIES(a_mod_bound, clock, reset, rsp_valid_ff, rsp_mod_ff < sbe_pkg::MOD_W'(sbe_pkg::MOD_PRIME))

endmodule
